// ===== sv/escfr_pkg.sv =====
`default_nettype none
package escfr_pkg;

	localparam int unsigned QDepth = 4;
	localparam int unsigned QPtrW  = $clog2(QDepth);
	localparam int unsigned QCntW  = $clog2(QDepth + 1);
	localparam int unsigned MaxBytes = 4;

	localparam logic [7:0] EscMask   = 8'hFC;
	localparam logic [7:0] EscMark   = 8'h10;
	localparam logic [5:0] SixBits   = 6'h3F;
	localparam logic [7:0] CsAssert  = 8'h82;
	localparam logic [7:0] CsRelease = 8'h80;
	localparam logic [7:0] LowTwo    = 8'h03;

	typedef enum logic [1:0] {
		OP_BEGIN   = 2'd0,
		OP_PAYLOAD = 2'd1,
		OP_END     = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	// one classified item: the bytes to send and the index of its last byte
	typedef struct packed {
		logic [MaxBytes-1:0][7:0] bytes;
		logic [1:0]               last_idx;
	} desc_t;

	typedef struct packed {
		logic  valid;
		desc_t desc;
	} q_head_t;

	function automatic logic is_reserved(input logic [7:0] b);
		return (b & EscMask) == EscMark;
	endfunction

endpackage
`default_nettype wire

// ===== sv/escfr_front.sv =====
`default_nettype none
module escfr_front import escfr_pkg::*; (
	input  wire logic [1:0]  opcode,
	input  wire logic [7:0]  payload_byte,
	input  wire logic [11:0] read_count,
	output desc_t            desc,
	output logic             has_bytes
);

	op_t        op;
	logic [7:0] hi;
	logic [7:0] lo;

	assign op = op_t'(opcode);
	assign hi = {2'b00, read_count[11:6] & SixBits};
	assign lo = {2'b00, read_count[5:0] & SixBits};

	always_comb begin
		desc      = '0;
		has_bytes = 1'b1;
		unique case (op)
			OP_BEGIN: begin
				desc.last_idx = 2'd3;
				desc.bytes[3] = CsAssert;
				if (is_reserved(lo)) begin
					desc.bytes[0] = hi;
					desc.bytes[1] = EscMark;
					desc.bytes[2] = lo & LowTwo;
				end else begin
					desc.bytes[0] = 8'h00;
					desc.bytes[1] = hi;
					desc.bytes[2] = lo;
				end
			end
			OP_PAYLOAD: begin
				if (is_reserved(payload_byte)) begin
					desc.bytes[0] = EscMark;
					desc.bytes[1] = payload_byte & LowTwo;
					desc.last_idx = 2'd1;
				end else begin
					desc.bytes[0] = payload_byte;
					desc.last_idx = 2'd0;
				end
			end
			OP_END: begin
				desc.bytes[0] = CsRelease;
				desc.last_idx = 2'd0;
			end
			default: begin
				// unused opcode: drop the item
				has_bytes = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/escfr_queue.sv =====
`default_nettype none
module escfr_queue import escfr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire desc_t push_desc,
	output logic       full,
	output q_head_t    head,
	input  wire logic  pop
);

	desc_t             entry_q [QDepth];
	logic [QPtrW-1:0]  wr_ptr_q;
	logic [QPtrW-1:0]  rd_ptr_q;
	logic [QCntW-1:0]  cnt_q;

	assign full       = cnt_q == QCntW'(QDepth);
	assign head.valid = cnt_q != '0;
	assign head.desc  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/escfr_back.sv =====
`default_nettype none
module escfr_back import escfr_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire q_head_t head,
	output logic         pop,
	output logic         m_tvalid,
	input  wire logic    m_tready,
	output logic [7:0]   m_tdata,
	output logic         m_tlast
);

	logic [1:0] idx_q;
	logic       vld_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       load;
	logic       is_last;

	assign load    = (!vld_q || m_tready) && head.valid;
	assign is_last = idx_q == head.desc.last_idx;
	assign pop     = load && is_last;

	assign m_tvalid = vld_q;
	assign m_tdata  = byte_q;
	assign m_tlast  = last_q;

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head.desc.bytes[idx_q];
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				vld_q <= 1'b1;
			end else if (m_tready) begin
				vld_q <= 1'b0;
			end
			// advance within the item, restart on the next one
			if (load) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/escaped_spi_command_framer.sv =====
// Bytes of a taken beat are registered in the descriptor queue, then in the output stage.
// Throughput: one output byte per cycle while m_tready is high; an item yields 1..4 bytes.
// Input beats are taken every cycle while the 4-entry descriptor queue has room.
// Reset (arst_n low, async): queue emptied, output invalid, byte index zeroed; no other state.
`default_nettype none
module escaped_spi_command_framer import escfr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // [7:0] payload_byte, [19:8] read_count, [23:20] zero
	input  wire logic [1:0]  s_tuser,  // [1:0] opcode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // [7:0] out_byte
	output logic             m_tlast
);

	desc_t   desc;
	logic    has_bytes;
	logic    full;
	logic    push;
	logic    pop;
	q_head_t head;

	escfr_front u_front (
		.opcode       (s_tuser),
		.payload_byte (s_tdata[7:0]),
		.read_count   (s_tdata[19:8]),
		.desc         (desc),
		.has_bytes    (has_bytes)
	);

	assign s_tready = !full;
	assign push     = s_tvalid && s_tready && has_bytes;

	escfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (desc),
		.full      (full),
		.head      (head),
		.pop       (pop)
	);

	escfr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none
module testbench;
	import escfr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} uart_beat_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;  // [7:0] payload_byte, [19:8] read_count, [23:20] zero
	logic [1:0]  s_tuser  = '0;  // [1:0] opcode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // [7:0] out_byte
	logic        m_tlast;

	uart_beat_t uart_bytes_due[$];
	int unsigned mismatch_count = 0;
	int unsigned bytes_checked  = 0;
	int unsigned n_begin = 0, n_payload = 0, n_end = 0, n_ignored = 0;
	int unsigned hold_request = 0;
	int unsigned longest_hold = 0;
	bit          idling_on = 1'b1;

	escaped_spi_command_framer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #6 clk = ~clk;

	function automatic int draw_wait();
		if (!idling_on)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	function automatic void push_uart_byte(input logic [7:0] b);
		uart_beat_t beat;
		beat.data = b;
		beat.last = 1'b0;
		uart_bytes_due.push_back(beat);
	endfunction

	// reserved values 0x10..0x13 go out as the mark and the low two bits
	function automatic void push_escaped(input logic [7:0] b);
		if (b[7:2] == 6'b000100) begin
			push_uart_byte(EscMark);
			push_uart_byte({6'b0, b[1:0]});
		end else begin
			push_uart_byte(b);
		end
	endfunction

	function automatic void encode_item(input op_t op, input logic [7:0] pay,
			input logic [11:0] cnt);
		logic [5:0] hi;
		logic [5:0] lo;
		int unsigned start;
		start = uart_bytes_due.size();
		hi = cnt[11:6];
		lo = cnt[5:0];
		case (op)
			OP_BEGIN: begin
				// hi stays raw even when it falls in the reserved range
				if (lo[5:2] == 4'b0100) begin
					push_uart_byte({2'b0, hi});
					push_uart_byte(EscMark);
					push_uart_byte({6'b0, lo[1:0]});
				end else begin
					push_uart_byte(8'h00);
					push_uart_byte({2'b0, hi});
					push_uart_byte({2'b0, lo});
				end
				push_escaped(CsAssert);
			end
			OP_PAYLOAD: push_escaped(pay);
			OP_END:     push_escaped(CsRelease);
			default:    ;
		endcase
		if (uart_bytes_due.size() > start)
			uart_bytes_due[uart_bytes_due.size() - 1].last = 1'b1;
	endfunction

	task automatic send_item(input op_t op, input logic [7:0] pay, input logic [11:0] cnt);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'h0, cnt, pay};
		do @(posedge clk); while (!s_tready);
		encode_item(op, pay, cnt);
		case (op)
			OP_BEGIN:   n_begin++;
			OP_PAYLOAD: n_payload++;
			OP_END:     n_end++;
			default:    n_ignored++;
		endcase
	endtask

	function automatic logic [11:0] random_count();
		// bias toward a reserved low half of the count
		if ($urandom_range(0, 2) == 0)
			return {6'($urandom), 4'b0100, 2'($urandom)};
		return 12'($urandom);
	endfunction

	function automatic logic [7:0] random_byte();
		if ($urandom_range(0, 2) == 0)
			return {6'b000100, 2'($urandom)};
		return 8'($urandom);
	endfunction

	task automatic test_begin_headers();
		send_item(OP_BEGIN, 8'h00, 12'h000);
		send_item(OP_BEGIN, 8'hFF, 12'hFFF);
		send_item(OP_BEGIN, 8'h5A, {6'h2A, 6'h10});
		send_item(OP_BEGIN, 8'hA5, {6'h00, 6'h13});
		send_item(OP_BEGIN, 8'h00, {6'h3F, 6'h11});
		send_item(OP_BEGIN, 8'h00, {6'h10, 6'h05});
		send_item(OP_BEGIN, 8'h00, {6'h13, 6'h12});
		send_item(OP_BEGIN, 8'h00, {6'h01, 6'h0F});
		send_item(OP_BEGIN, 8'h00, {6'h15, 6'h14});
	endtask

	task automatic test_payload_bytes();
		send_item(OP_PAYLOAD, 8'h00, 12'hFFF);
		send_item(OP_PAYLOAD, 8'hFF, 12'h000);
		send_item(OP_PAYLOAD, 8'h0F, 12'h000);
		send_item(OP_PAYLOAD, 8'h10, 12'h000);
		send_item(OP_PAYLOAD, 8'h11, 12'h000);
		send_item(OP_PAYLOAD, 8'h12, 12'h000);
		send_item(OP_PAYLOAD, 8'h13, 12'h000);
		send_item(OP_PAYLOAD, 8'h14, 12'h000);
		send_item(OP_PAYLOAD, 8'h82, 12'h000);
		send_item(OP_PAYLOAD, 8'h80, 12'h000);
	endtask

	task automatic test_end_and_unused();
		send_item(OP_END, 8'hFF, 12'hFFF);
		send_item(OP_NONE, 8'hFF, 12'hFFF);
		send_item(OP_NONE, 8'h00, 12'h000);
		send_item(OP_END, 8'h13, 12'h010);
	endtask

	// stall the output long enough for the descriptor queue to fill
	task automatic test_backpressure();
		int i;
		idling_on = 1'b0;
		hold_request = 300;
		send_item(OP_BEGIN, 8'h00, random_count());
		for (i = 0; i < 16; i++)
			send_item(OP_PAYLOAD, random_byte(), 12'($urandom));
		send_item(OP_END, 8'h00, 12'h000);
		idling_on = 1'b1;
	endtask

	task automatic test_random_frames();
		int frame;
		int n;
		int i;
		bit broken;
		frame = 0;
		while (n_begin + n_payload + n_end < 255) begin
			frame++;
			idling_on = (frame % 6 != 0);
			if ($urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 3);
				for (i = 0; i < n; i++)
					send_item(op_t'($urandom_range(0, 3)), 8'($urandom), 12'($urandom));
			end else begin
				broken = ($urandom_range(0, 7) == 0);
				if (!(broken && $urandom_range(0, 1)))
					send_item(OP_BEGIN, 8'($urandom), random_count());
				n = $urandom_range(0, 8);
				for (i = 0; i < n; i++)
					send_item(OP_PAYLOAD, random_byte(), 12'($urandom));
				if (!(broken && $urandom_range(0, 1)))
					send_item(OP_END, 8'($urandom), 12'($urandom));
			end
		end
		idling_on = 1'b1;
	endtask

	// output side: random stalls, then compare each beat with the oldest expected byte
	initial begin
		int stall;
		uart_beat_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request > 0) begin
				stall = hold_request;
				hold_request = 0;
				if (stall > longest_hold)
					longest_hold = stall;
			end else begin
				stall = draw_wait();
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			bytes_checked++;
			if (uart_bytes_due.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected beat, expected none, actual byte %02h last %0b",
					$realtime, m_tdata, m_tlast);
			end else begin
				want = uart_bytes_due.pop_front();
				if (m_tdata !== want.data) begin
					mismatch_count++;
					$display("%0t: out_byte expected %02h actual %02h",
						$realtime, want.data, m_tdata);
				end
				if (m_tlast !== want.last) begin
					mismatch_count++;
					$display("%0t: run_last expected %0b actual %0b",
						$realtime, want.last, m_tlast);
				end
			end
		end
	end

	initial begin
		int i;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_begin_headers();
		test_payload_bytes();
		test_end_and_unused();
		test_backpressure();
		test_random_frames();
		s_tvalid <= 1'b0;
		for (i = 0; i < 200000 && uart_bytes_due.size() != 0; i++)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (uart_bytes_due.size() != 0) begin
			mismatch_count++;
			$display("%0t: %0d expected bytes never arrived, expected 0 actual %0d",
				$realtime, uart_bytes_due.size(), uart_bytes_due.size());
		end
		$display("Sent %0d begin, %0d payload, %0d end and %0d unused-opcode items.",
			n_begin, n_payload, n_end, n_ignored);
		$display("Checked %0d output bytes, one output stall of %0d cycles, %0d errors.",
			bytes_checked, longest_hold, mismatch_count);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire
